// ----- hw/rtl/ssmm_pkg.sv -----
`timescale 1ns / 1ps

package ssmm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_SAMPLES = 1024;

  localparam int COUNT_W    = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W      = SAMPLE_BITS + COUNT_W - 1;
  localparam int SUMSQ_W    = 2 * SAMPLE_BITS + COUNT_W - 1;
  localparam int SQUARE_W   = 2 * SAMPLE_BITS;
  localparam int PROD_A_W   = COUNT_W + SUMSQ_W;
  localparam int PROD_B_W   = 2 * SUM_W;
  localparam int N2_W       = 2 * COUNT_W;

  // Shared divider: largest dividend is the variance numerator scaled by 2^16
  localparam int FRAC_BITS  = 8;
  localparam int DIVIDEND_W = PROD_A_W + 2 * FRAC_BITS;
  localparam int DIVISOR_W  = N2_W;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  // Scaled variance never exceeds 2^(2*SAMPLE_BITS + 2*FRAC_BITS - 2)
  localparam int ROOT_IN_W  = 2 * SAMPLE_BITS + 2 * FRAC_BITS;
  localparam int ROOT_OUT_W = ROOT_IN_W / 2;

  localparam int MEAN_W     = 24;
  localparam int DEV_W      = 23;
  localparam int STATUS_W   = 2;
  localparam int OUT_COUNT_W = 11;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_FIELD_W = 2 * SAMPLE_BITS + MEAN_W + DEV_W + OUT_COUNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_FEW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic accumulate;
    logic clear;
    logic products;
    logic div_start;
    logic div_sel_var;
    logic capture_mean;
    logic sqrt_start;
    logic capture_dev;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } stat_t;

endpackage

// ----- hw/rtl/ssmm_divider.sv -----
`timescale 1ns / 1ps

module ssmm_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [ssmm_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [ssmm_pkg::DIVISOR_W-1:0]  divisor,
  output logic [ssmm_pkg::DIVIDEND_W-1:0] quotient,
  output logic                            done
);

  localparam int DW  = ssmm_pkg::DIVIDEND_W;
  localparam int DVW = ssmm_pkg::DIVISOR_W;
  localparam int CW  = ssmm_pkg::DIV_CNT_W;

  logic [DVW-1:0] rem;
  logic [DW-1:0]  quo;
  logic [DVW-1:0] dvs;
  logic [CW-1:0]  cnt;
  logic           busy;

  logic [DVW:0]   partial;
  logic [DVW:0]   trial;
  logic           ge;

  // Restoring division, one quotient bit a cycle; quotient shifts in behind the dividend
  assign partial  = {rem, quo[DW-1]};
  assign ge       = partial >= {1'b0, dvs};
  assign trial    = partial - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // hold the divisor for the whole pass
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
      cnt <= CW'(DW - 1);
    end else if (busy) begin
      rem <= ge ? trial[DVW-1:0] : partial[DVW-1:0];
      quo <= {quo[DW-2:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

// ----- hw/rtl/ssmm_sqrt.sv -----
`timescale 1ns / 1ps

module ssmm_sqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [ssmm_pkg::ROOT_IN_W-1:0]  radicand,
  output logic [ssmm_pkg::ROOT_OUT_W-1:0] root,
  output logic                            done
);

  localparam int RW = ssmm_pkg::ROOT_IN_W;

  logic [RW-1:0] rest;
  logic [RW-1:0] acc;
  logic [RW-1:0] probe;
  logic          busy;

  logic [RW-1:0] trial;
  logic          ge;

  // Digit-by-digit root: probe walks down two bit places each cycle
  assign trial = acc + probe;
  assign ge    = rest >= trial;
  assign root  = acc[ssmm_pkg::ROOT_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (probe[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rest  <= radicand;
      acc   <= '0;
      probe <= RW'(1) << (RW - 2);
    end else if (busy) begin
      if (ge) begin
        rest <= rest - trial;
        acc  <= (acc >> 1) + probe;
      end else begin
        acc  <= acc >> 1;
      end
      probe <= probe >> 2;
    end
  end

endmodule

// ----- hw/rtl/ssmm_datapath.sv -----
`timescale 1ns / 1ps

module ssmm_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  ssmm_pkg::cmd_t                   cmd,
  output ssmm_pkg::stat_t                  stat,
  input  logic [ssmm_pkg::SAMPLE_BITS-1:0] sample,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ssmm_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic [ssmm_pkg::STATUS_W-1:0]    m_tuser
);

  localparam int SB  = ssmm_pkg::SAMPLE_BITS;
  localparam int CW  = ssmm_pkg::COUNT_W;
  localparam int FB  = ssmm_pkg::FRAC_BITS;
  localparam int PAD = ssmm_pkg::OUT_TDATA_W - ssmm_pkg::OUT_FIELD_W;

  logic [SB-1:0]                  running_min;
  logic [SB-1:0]                  running_max;
  logic [ssmm_pkg::SUM_W-1:0]     running_sum;
  logic [ssmm_pkg::SUMSQ_W-1:0]   running_sum_squares;
  logic [CW-1:0]                  running_count;
  logic                           overflow_seen;

  logic [ssmm_pkg::SQUARE_W-1:0]  square;

  logic [ssmm_pkg::PROD_A_W-1:0]  prod_a;
  logic [ssmm_pkg::PROD_B_W-1:0]  prod_b;
  logic [ssmm_pkg::N2_W-1:0]      count_sq;
  logic [ssmm_pkg::PROD_A_W-1:0]  prod_b_ext;
  logic [ssmm_pkg::PROD_A_W-1:0]  spread;

  logic [ssmm_pkg::DIVIDEND_W-1:0] dividend;
  logic [ssmm_pkg::DIVISOR_W-1:0]  divisor;
  logic [ssmm_pkg::DIVIDEND_W-1:0] quotient;
  logic                            div_done;
  logic [ssmm_pkg::ROOT_OUT_W-1:0] root;
  logic                            sqrt_done;

  logic [ssmm_pkg::MEAN_W-1:0]    mean_q8;
  logic [ssmm_pkg::DEV_W-1:0]     deviation_q8;

  logic [SB-1:0]                  out_min;
  logic [SB-1:0]                  out_max;
  logic [ssmm_pkg::MEAN_W-1:0]    out_mean;
  logic [ssmm_pkg::DEV_W-1:0]     out_dev;
  logic [ssmm_pkg::OUT_COUNT_W-1:0] out_count;
  logic [ssmm_pkg::STATUS_W-1:0]  out_status;

  logic                           empty_set;
  logic [ssmm_pkg::STATUS_W-1:0]  status_next;

  assign square = ssmm_pkg::SQUARE_W'(sample) * ssmm_pkg::SQUARE_W'(sample);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      running_min         <= '1;
      running_max         <= '0;
      running_sum         <= '0;
      running_sum_squares <= '0;
      running_count       <= '0;
      overflow_seen       <= 1'b0;
    end else if (cmd.accumulate) begin
      if (running_count >= CW'(ssmm_pkg::MAX_SAMPLES)) begin
        // drop words beyond capacity, remember it
        overflow_seen <= 1'b1;
      end else begin
        if (sample < running_min) running_min <= sample;
        if (sample > running_max) running_max <= sample;
        running_sum         <= running_sum + ssmm_pkg::SUM_W'(sample);
        running_sum_squares <= running_sum_squares + ssmm_pkg::SUMSQ_W'(square);
        running_count       <= running_count + 1'b1;
      end
    end
  end

  // n*sumsq - sum^2 and n^2, registered before the subtract
  always_ff @(posedge clk) begin
    if (cmd.products) begin
      prod_a   <= ssmm_pkg::PROD_A_W'(running_count) *
                  ssmm_pkg::PROD_A_W'(running_sum_squares);
      prod_b   <= ssmm_pkg::PROD_B_W'(running_sum) * ssmm_pkg::PROD_B_W'(running_sum);
      count_sq <= ssmm_pkg::N2_W'(running_count) * ssmm_pkg::N2_W'(running_count);
    end
  end

  assign prod_b_ext = ssmm_pkg::PROD_A_W'(prod_b);
  assign spread     = (prod_a > prod_b_ext) ? prod_a - prod_b_ext : '0;

  always_comb begin
    if (cmd.div_sel_var) begin
      dividend = {spread, (2 * FB)'(0)};
      divisor  = count_sq;
    end else begin
      dividend = ssmm_pkg::DIVIDEND_W'({running_sum, FB'(0)});
      divisor  = ssmm_pkg::DIVISOR_W'(running_count);
    end
  end

  ssmm_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  ssmm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (quotient[ssmm_pkg::ROOT_IN_W-1:0]),
    .root     (root),
    .done     (sqrt_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture_mean) mean_q8      <= quotient[ssmm_pkg::MEAN_W-1:0];
    if (cmd.capture_dev)  deviation_q8 <= root[ssmm_pkg::DEV_W-1:0];
  end

  assign empty_set = running_count == '0;

  always_comb begin
    if (overflow_seen)              status_next = ssmm_pkg::STATUS_OVERFLOW;
    else if (running_count < CW'(2)) status_next = ssmm_pkg::STATUS_TOO_FEW;
    else                            status_next = ssmm_pkg::STATUS_OK;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_min    <= empty_set ? '0 : running_min;
      out_max    <= empty_set ? '0 : running_max;
      out_mean   <= empty_set ? '0 : mean_q8;
      out_dev    <= empty_set ? '0 : deviation_q8;
      out_count  <= ssmm_pkg::OUT_COUNT_W'(running_count);
      out_status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {PAD'(0), out_count, out_dev, out_mean, out_max, out_min};
  assign m_tuser = out_status;

  assign stat.div_done  = div_done;
  assign stat.sqrt_done = sqrt_done;
  assign stat.out_free  = !m_tvalid || m_tready;

endmodule

// ----- hw/rtl/ssmm_ctrl.sv -----
`timescale 1ns / 1ps

module ssmm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  logic            s_tlast,
  output logic            s_tready,
  input  ssmm_pkg::stat_t stat,
  output ssmm_pkg::cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PROD = 3'd1;
  localparam logic [2:0] ST_MEAN = 3'd2;
  localparam logic [2:0] ST_VAR  = 3'd3;
  localparam logic [2:0] ST_ROOT = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready       = 1'b1;
        cmd.accumulate = s_tvalid;
        if (s_tvalid && s_tlast) state_next = ST_PROD;
      end
      ST_PROD: begin
        // mean division starts straight from the accumulators
        cmd.products  = 1'b1;
        cmd.div_start = 1'b1;
        state_next    = ST_MEAN;
      end
      ST_MEAN: begin
        if (stat.div_done) begin
          cmd.capture_mean = 1'b1;
          cmd.div_start    = 1'b1;
          cmd.div_sel_var  = 1'b1;
          state_next       = ST_VAR;
        end
      end
      ST_VAR: begin
        if (stat.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_next     = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (stat.sqrt_done) begin
          cmd.capture_dev = 1'b1;
          state_next      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold until the previous result word has gone
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.clear    = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/sample_statistics_min_max_mean_sd.sv -----
`timescale 1ns / 1ps

// Channel | Side   | Handshake                   | Payload
// s_      | input  | s_tvalid / s_tready         | s_tdata: sample; s_tlast: last
// m_      | output | m_tvalid / m_tready         | m_tdata: min, max, mean, dev, count;
//         |        |                             | m_tuser: status
//
// One sample word is taken per cycle until the word marked last.
// After it the set is closed by two passes of the shared one-bit-per-cycle
// divider (mean, then scaled variance) and a 24-step square root; no input
// is taken meanwhile.
// Reset is synchronous on rst and empties the accumulators and the output.
// A finished result sits in the output register; the next set's samples are
// taken while it waits, and only the next result waits for m_tready.

module sample_statistics_min_max_mean_sd (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [15:0] sample
  input  logic [ssmm_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [15:0] minimum, [31:16] maximum, [55:32] mean_q8, [78:56] deviation_q8,
  // [89:79] sample_count, [95:90] zero
  output logic [ssmm_pkg::OUT_TDATA_W-1:0] m_tdata,
  // [1:0] status
  output logic [ssmm_pkg::STATUS_W-1:0]    m_tuser
);

  ssmm_pkg::cmd_t  cmd;
  ssmm_pkg::stat_t stat;

  ssmm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ssmm_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .sample   (s_tdata[ssmm_pkg::SAMPLE_BITS-1:0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("result word overwritten before it was taken");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("input taken while a set is being closed");

  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.load_out))
    else $error("result valid without a load");
`endif

endmodule

// ----- bench/sample_statistics_min_max_mean_sd_tb.sv -----
`timescale 1ns / 1ps

module sample_statistics_min_max_mean_sd_tb;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
  } sample_word_t;

  typedef struct packed {
    logic [15:0]                 minimum;
    logic [15:0]                 maximum;
    logic [ssmm_pkg::MEAN_W-1:0] mean;
    logic [ssmm_pkg::DEV_W-1:0]  dev;
    logic [10:0]                 count;
    logic [1:0]                  status;
  } stats_t;

  typedef enum {FILL_FULL, FILL_EDGE, FILL_LOW, FILL_HIGH} fill_t;

  localparam int HOLD_CYCLES = 800;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [ssmm_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                             s_tlast = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [ssmm_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic [ssmm_pkg::STATUS_W-1:0]    m_tuser;

  sample_word_t samples_waiting[$];
  stats_t       stats_due[$];
  sample_word_t next_word;
  stats_t       want;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_queued   = 0;
  int fail_count     = 0;
  int hold_left      = 0;
  bit hold_req       = 1'b0;

  // running accumulators of the predictor
  logic [15:0] acc_min   = 16'hFFFF;
  logic [15:0] acc_max   = '0;
  bit [63:0]   acc_sum   = '0;
  bit [63:0]   acc_sumsq = '0;
  int          acc_count = 0;
  bit          acc_ovf   = 1'b0;

  sample_statistics_min_max_mean_sd u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #4 clk = ~clk;

  function automatic bit [63:0] int_sqrt(input bit [63:0] x);
    bit [63:0] root;
    bit [63:0] bitv;
    bit [63:0] rem;
    root = '0;
    bitv = 64'd1 << 62;
    rem  = x;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  -= root + bitv;
        root  = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  task automatic fold_sample(input logic [15:0] smp, input logic lst);
    stats_t    r;
    bit [63:0] sq;
    bit [63:0] n;
    bit [63:0] n2;
    bit [63:0] a;
    bit [63:0] b;
    bit [63:0] d;
    bit [63:0] q;
    if (acc_count >= ssmm_pkg::MAX_SAMPLES) begin
      acc_ovf = 1'b1;
    end else begin
      sq = smp;
      if (smp < acc_min) acc_min = smp;
      if (smp > acc_max) acc_max = smp;
      acc_sum   += sq;
      acc_sumsq += sq * sq;
      acc_count++;
    end
    if (lst) begin
      r = '0;
      n = acc_count;
      if (n != 0) begin
        n2 = n * n;
        a  = n * acc_sumsq;
        b  = acc_sum * acc_sum;
        r.minimum = acc_min;
        r.maximum = acc_max;
        r.mean    = ssmm_pkg::MEAN_W'((acc_sum << 8) / n);
        if (a > b) begin
          d = a - b;
          q = (d / n2) * 64'd65536 + ((d % n2) * 64'd65536) / n2;
          r.dev = ssmm_pkg::DEV_W'(int_sqrt(q));
        end
      end
      r.count = 11'(n);
      if (acc_ovf) r.status = ssmm_pkg::STATUS_OVERFLOW;
      else if (n < 2) r.status = ssmm_pkg::STATUS_TOO_FEW;
      else r.status = ssmm_pkg::STATUS_OK;
      stats_due.push_back(r);
      // start the next set afresh
      acc_min   = 16'hFFFF;
      acc_max   = '0;
      acc_sum   = '0;
      acc_sumsq = '0;
      acc_count = 0;
      acc_ovf   = 1'b0;
    end
  endtask

  task automatic note_failure(input string what, input longint expv, input longint actv);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch %s: expected %0d, got %0d", what, expv, actv);
  endtask

  function automatic logic [15:0] pick_sample(input fill_t fill);
    case (fill)
      FILL_EDGE: begin
        case ($urandom_range(3))
          0: return 16'h0000;
          1: return 16'hFFFF;
          2: return 16'h0001;
          default: return 16'hFFFE;
        endcase
      end
      FILL_LOW:  return 16'($urandom_range(15));
      FILL_HIGH: return 16'($urandom_range(65535, 65500));
      default:   return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic push_word(input logic [15:0] smp, input logic lst);
    sample_word_t w;
    w.sample = smp;
    w.last   = lst;
    samples_waiting.push_back(w);
    items_queued++;
  endtask

  task automatic push_set(input int len, input fill_t fill);
    for (int i = 0; i < len; i++) push_word(pick_sample(fill), i == len - 1);
  endtask

  task automatic add_sets(input int target);
    int    stop;
    int    len;
    int    roll;
    fill_t fill;
    stop = items_queued + target;
    while (items_queued < stop) begin
      roll = $urandom_range(99);
      if (roll < 10) len = 1;
      else if (roll < 85) len = $urandom_range(10, 2);
      else len = $urandom_range(40, 11);
      roll = $urandom_range(99);
      if (roll < 55) fill = FILL_FULL;
      else if (roll < 70) fill = FILL_EDGE;
      else if (roll < 85) fill = FILL_LOW;
      else fill = FILL_HIGH;
      push_set(len, fill);
    end
  endtask

  // hold until every queued word has gone in and every result has come out
  task automatic wait_drained();
    while (samples_waiting.size() != 0 || s_tvalid || stats_due.size() != 0)
      @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (samples_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_word = samples_waiting.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= next_word.sample;
        s_tlast  <= next_word.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) fold_sample(s_tdata, s_tlast);
  end

  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_req) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !hold_req && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (stats_due.size() == 0) begin
        note_failure("result with none pending", 0, m_tdata[15:0]);
      end else begin
        want = stats_due.pop_front();
        if (m_tdata[15:0] !== want.minimum)
          note_failure("minimum", want.minimum, m_tdata[15:0]);
        if (m_tdata[31:16] !== want.maximum)
          note_failure("maximum", want.maximum, m_tdata[31:16]);
        if (m_tdata[55:32] !== want.mean)
          note_failure("mean_q8", want.mean, m_tdata[55:32]);
        if (m_tdata[78:56] !== want.dev)
          note_failure("deviation_q8", want.dev, m_tdata[78:56]);
        if (m_tdata[89:79] !== want.count)
          note_failure("sample_count", want.count, m_tdata[89:79]);
        if (m_tuser !== want.status)
          note_failure("status", want.status, m_tuser);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // extremes, single-sample sets and flat sets
    push_word(16'h0000, 1'b1);
    push_word(16'hFFFF, 1'b1);
    push_word(16'h0000, 1'b0);
    push_word(16'hFFFF, 1'b1);
    push_word(16'hFFFF, 1'b0);
    push_word(16'hFFFF, 1'b1);
    push_word(16'hAAAA, 1'b0);
    push_word(16'h5555, 1'b1);
    push_word(16'd1, 1'b0);
    push_word(16'd2, 1'b0);
    push_word(16'd3, 1'b1);
    push_word(16'hFFFF, 1'b0);
    push_word(16'h0000, 1'b0);
    push_word(16'hFFFF, 1'b0);
    push_word(16'h0000, 1'b1);
    push_set(6, FILL_FULL);
    push_set(3, FILL_LOW);
    add_sets(100);
    // run past capacity so the trailing words are dropped
    push_set(ssmm_pkg::MAX_SAMPLES + $urandom_range(4, 1), FILL_EDGE);
    wait_drained();

    // long receiver hold-off while words keep coming
    hold_req = 1'b1;
    @(negedge clk);
    hold_req = 1'b0;
    add_sets(40);
    wait_drained();

    send_idle_pct = 66;
    add_sets(130);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 66;
    add_sets(130);
    wait_drained();

    send_idle_pct  = 8;
    recv_stall_pct = 8;
    add_sets(130);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    add_sets(40);
    wait_drained();

    repeat (400) @(posedge clk);
    if (stats_due.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
